// ===== design/robot_frame_velocity_command_defines.svh =====
// Assertion macros shared by the velocity command checker.
`ifndef ROBOT_FRAME_VELOCITY_COMMAND_DEFINES_SVH
`define ROBOT_FRAME_VELOCITY_COMMAND_DEFINES_SVH

// Checked only while the block is out of reset.
`define RFVC_CHECK(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("rfvc checker: property failed");

// Checked at every edge, reset included.
`define RFVC_CHECK_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("rfvc checker: reset property failed");

`endif

// ===== design/rfvc_pkg.sv =====
// Shared types, constants and the sine table builder for the velocity command block.
`default_nettype none
package rfvc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_BITS_DEF  = 12;
  localparam int SPEED_W         = 16;
  localparam int CFG_DATA_W      = 15;
  localparam int CFG_INDEX_W     = 3;
  localparam int QUOT_W          = 15;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_FLIP_Y         = 3'd0;
  localparam cfg_index_t REG_ROTATE_CW      = 3'd1;
  localparam cfg_index_t REG_MAX_SPEED      = 3'd2;
  localparam cfg_index_t REG_ANGLE_ADJUST   = 3'd3;
  localparam cfg_index_t REG_AXIS_TOLERANCE = 3'd4;
  localparam cfg_index_t REG_MAX_TURN_SPEED = 3'd5;

  typedef struct packed {
    logic                  flip_y;
    logic                  rotate_cw;
    logic [CFG_DATA_W-1:0] max_speed;
    logic                  adjust_on;
    logic [CFG_DATA_W-1:0] axis_tol;
    logic [CFG_DATA_W-1:0] max_turn;
  } rfvc_cfg_t;

  typedef struct packed {
    logic y_major;
    logic neg_x;
    logic neg_y;
    logic zero;
  } rfvc_flags_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  // Q0.15 sine of r quarter-turn steps, r in [0, 2^(ab-2)], from a Q30 Taylor series.
  function automatic logic [14:0] quarter_sine(input int unsigned r, input int unsigned ab);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q15;
    x    = (HALF_PI_Q30 * 64'(r)) >> (ab - 2);
    term = x;
    sum  = x;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if ((n & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q15 = (sum + 64'd16384) >> 15;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return q15[14:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/rfvc_in_if.sv =====
// Input channel carrying one robot pose and target point per transaction.
`default_nettype none
interface rfvc_in_if #(
  parameter int COORD_WIDTH = rfvc_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_BITS  = rfvc_pkg::ANGLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] robot_x;
  logic signed [COORD_WIDTH-1:0] robot_y;
  logic        [ANGLE_BITS-1:0]  robot_heading;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;

  modport source (output valid, robot_x, robot_y, robot_heading, target_x, target_y,
                  input ready);
  modport sink (input valid, robot_x, robot_y, robot_heading, target_x, target_y,
                output ready);
endinterface
`default_nettype wire

// ===== design/rfvc_out_if.sv =====
// Result channel carrying one velocity command per transaction.
`default_nettype none
interface rfvc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rfvc_pkg::SPEED_W-1:0]  speed_x;
  logic signed [rfvc_pkg::SPEED_W-1:0]  speed_y;
  logic [rfvc_pkg::CFG_DATA_W-1:0]      turn_speed;

  modport source (output valid, speed_x, speed_y, turn_speed, input ready);
  modport sink (input valid, speed_x, speed_y, turn_speed, output ready);
endinterface
`default_nettype wire

// ===== design/robot_frame_velocity_command.sv =====
// Top level of the robot-frame velocity command pipeline.
//
// Usage: one transaction on in_chan carries a robot pose (x, y, heading as a
// binary angle) and a target point. One transaction on out_chan returns the
// velocity command for it: speed_x and speed_y in the robot frame, with the
// dominant component at plus or minus max_speed, and turn_speed.
// Both channels use valid/ready; a transaction completes on a rising clock edge
// where both are high. Results leave in the order items arrive.
// From input transaction to output valid, an item passes through four front
// stages (table read, rotation multiply, sum and axis pick, scaling multiply),
// fifteen divider stages that each produce one quotient bit, and the output
// register. Throughput is one transaction per cycle when out_chan is not stalled,
// set by the one-bit-per-stage divider pipeline and the two-port sine ROM read.
// Every stage holds its own valid bit, so bubbles close up: when the receiver
// stalls, the output register holds its result and earlier stages keep
// accepting until the pipeline is full; nothing is dropped or repeated.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// must only change while no transaction is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// register defaults: max_speed and max_turn_speed 1000, everything else 0.
`default_nettype none
module robot_frame_velocity_command #(
  parameter int COORD_WIDTH = rfvc_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_BITS  = rfvc_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rfvc_in_if.sink                              in_chan,
  rfvc_out_if.source                           out_chan,
  input  wire logic                            cfg_we,
  input  wire rfvc_pkg::cfg_index_t            cfg_index,
  input  wire logic [rfvc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rfvc_pkg::*;

  localparam int AW = COORD_WIDTH + 1;
  localparam int NW = AW + QUOT_W;

  // Configuration registers, decoded from the write port.
  rfvc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flip_y    <= 1'b0;
      cfg_r.rotate_cw <= 1'b0;
      cfg_r.max_speed <= CFG_DATA_W'(1000);
      cfg_r.adjust_on <= 1'b0;
      cfg_r.axis_tol  <= '0;
      cfg_r.max_turn  <= CFG_DATA_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLIP_Y:         cfg_r.flip_y    <= cfg_wdata[0];
        REG_ROTATE_CW:      cfg_r.rotate_cw <= cfg_wdata[0];
        REG_MAX_SPEED:      cfg_r.max_speed <= cfg_wdata;
        REG_ANGLE_ADJUST:   cfg_r.adjust_on <= cfg_wdata[0];
        REG_AXIS_TOLERANCE: cfg_r.axis_tol  <= cfg_wdata;
        REG_MAX_TURN_SPEED: cfg_r.max_turn  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Links between the front stages, the divider stages and the output register.
  logic          stg_valid [QUOT_W+1];
  logic          stg_ready [QUOT_W+1];
  logic [NW-1:0] stg_work  [QUOT_W+1];
  logic [AW-1:0] stg_den   [QUOT_W+1];
  rfvc_flags_t   stg_flags [QUOT_W+1];

  rfvc_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg_r),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_work  (stg_work[0]),
    .out_den   (stg_den[0]),
    .out_flags (stg_flags[0])
  );

  for (genvar i = 0; i < QUOT_W; i++) begin : g_div
    rfvc_div_stage #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_work   (stg_work[i]),
      .in_den    (stg_den[i]),
      .in_flags  (stg_flags[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_work  (stg_work[i+1]),
      .out_den   (stg_den[i+1]),
      .out_flags (stg_flags[i+1])
    );
  end

  // Output register: signs are applied, the zero vector is forced to zero and
  // the axis tolerance test picks the turn speed.
  logic                       out_en;
  logic                       ov_r;
  logic [QUOT_W-1:0]          quot;
  rfvc_flags_t                fl;
  logic                       neg_major, neg_minor;
  logic signed [SPEED_W-1:0]  maj_v, min_v;
  logic signed [SPEED_W-1:0]  sx_nxt, sy_nxt;
  logic [CFG_DATA_W-1:0]      turn_nxt;
  logic signed [SPEED_W-1:0]  sx_r, sy_r;
  logic [CFG_DATA_W-1:0]      turn_r;

  assign out_en            = !ov_r || out_chan.ready;
  assign stg_ready[QUOT_W] = out_en;

  always_comb begin
    quot      = stg_work[QUOT_W][QUOT_W-1:0];
    fl        = stg_flags[QUOT_W];
    neg_major = fl.y_major ? fl.neg_y : fl.neg_x;
    neg_minor = fl.y_major ? fl.neg_x : fl.neg_y;
    maj_v     = neg_major ? -$signed({1'b0, cfg_r.max_speed}) : $signed({1'b0, cfg_r.max_speed});
    min_v     = neg_minor ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    if (fl.zero) begin
      sx_nxt   = '0;
      sy_nxt   = '0;
      turn_nxt = '0;
    end else begin
      sx_nxt   = fl.y_major ? min_v : maj_v;
      sy_nxt   = fl.y_major ? maj_v : min_v;
      turn_nxt = (cfg_r.adjust_on && !(quot < cfg_r.axis_tol)) ? cfg_r.max_turn : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_en) begin
      ov_r <= stg_valid[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      turn_r <= turn_nxt;
    end
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.speed_x    = sx_r;
  assign out_chan.speed_y    = sy_r;
  assign out_chan.turn_speed = turn_r;

  // The remainder and divisor leave the last divider stage unused.
  logic unused_tail;
  assign unused_tail = ^{stg_work[QUOT_W][NW-1:QUOT_W], stg_den[QUOT_W]};
endmodule
`default_nettype wire

// ===== design/rfvc_front.sv =====
// Front pipeline: displacement and table lookup, rotation products, sums, scaling product.
`default_nettype none
module rfvc_front #(
  parameter int COORD_WIDTH = rfvc_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_BITS  = rfvc_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  rfvc_in_if.sink                      in_chan,
  input  wire rfvc_pkg::rfvc_cfg_t     cfg,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [COORD_WIDTH+rfvc_pkg::QUOT_W:0] out_work,
  output logic [COORD_WIDTH:0]         out_den,
  output rfvc_pkg::rfvc_flags_t        out_flags
);
  import rfvc_pkg::*;

  localparam int QN = 2 ** (ANGLE_BITS - 2);
  localparam int DW = COORD_WIDTH + 1;
  localparam int TW = COORD_WIDTH + 1;
  localparam int VW = COORD_WIDTH + 2;
  localparam int AW = COORD_WIDTH + 1;
  localparam int PW = COORD_WIDTH + 17;
  localparam int NW = AW + QUOT_W;
  localparam int RAW = ANGLE_BITS - 1;

  // Quarter-wave sine ROM with registered read on two ports.
  logic [14:0] sine_rom [QN+1];
  for (genvar g = 0; g <= QN; g++) begin : g_rom
    assign sine_rom[g] = quarter_sine(g, ANGLE_BITS);
  end

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  // Stage 1 signals.
  logic signed [DW-1:0] dx_nxt, dy_raw, dy_nxt;
  logic [ANGLE_BITS-1:0] cos_idx;
  logic [RAW-1:0] sin_addr, cos_addr;
  logic signed [DW-1:0] dx1_r, dy1_r;
  logic [14:0] sinm1_r, cosm1_r;
  logic sneg1_r, cneg1_r;

  // Stage 2 signals.
  logic signed [15:0] sin_v, cos_v;
  logic signed [PW-1:0] prod_dc, prod_ds, prod_yc, prod_ys;
  logic signed [TW-1:0] dc2_r, ds2_r, yc2_r, ys2_r;

  // Stage 3 signals.
  logic signed [VW-1:0] vx, vy, neg_vx, neg_vy;
  logic [AW-1:0] ax, ay;
  logic [AW-1:0] maj3_r, min3_r;
  rfvc_flags_t flags3_r, flags3_nxt;

  // Stage 4 signals.
  logic [NW-1:0] work4_r;
  logic [AW-1:0] den4_r;
  rfvc_flags_t flags4_r;

  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_chan.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_chan.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Displacement and table addressing by quadrant symmetry.
  always_comb begin
    dx_nxt  = DW'(in_chan.target_x) - DW'(in_chan.robot_x);
    dy_raw  = DW'(in_chan.target_y) - DW'(in_chan.robot_y);
    dy_nxt  = cfg.flip_y ? -dy_raw : dy_raw;
    cos_idx = in_chan.robot_heading + ANGLE_BITS'(QN);
    sin_addr = in_chan.robot_heading[ANGLE_BITS-2] ?
               RAW'(QN) - {1'b0, in_chan.robot_heading[ANGLE_BITS-3:0]} :
               {1'b0, in_chan.robot_heading[ANGLE_BITS-3:0]};
    cos_addr = cos_idx[ANGLE_BITS-2] ?
               RAW'(QN) - {1'b0, cos_idx[ANGLE_BITS-3:0]} :
               {1'b0, cos_idx[ANGLE_BITS-3:0]};
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dx1_r   <= dx_nxt;
      dy1_r   <= dy_nxt;
      sinm1_r <= sine_rom[sin_addr];
      cosm1_r <= sine_rom[cos_addr];
      sneg1_r <= in_chan.robot_heading[ANGLE_BITS-1];
      cneg1_r <= cos_idx[ANGLE_BITS-1];
    end
  end

  // Rotation products, each floored by an arithmetic shift of 15.
  always_comb begin
    sin_v   = sneg1_r ? -$signed({1'b0, sinm1_r}) : $signed({1'b0, sinm1_r});
    cos_v   = cneg1_r ? -$signed({1'b0, cosm1_r}) : $signed({1'b0, cosm1_r});
    prod_dc = PW'(dx1_r) * PW'(cos_v);
    prod_ds = PW'(dx1_r) * PW'(sin_v);
    prod_yc = PW'(dy1_r) * PW'(cos_v);
    prod_ys = PW'(dy1_r) * PW'(sin_v);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      dc2_r <= prod_dc[TW+14:15];
      ds2_r <= prod_ds[TW+14:15];
      yc2_r <= prod_yc[TW+14:15];
      ys2_r <= prod_ys[TW+14:15];
    end
  end

  // Rotated vector, magnitudes and choice of the major axis.
  always_comb begin
    if (cfg.rotate_cw) begin
      vx = VW'(dc2_r) - VW'(ys2_r);
      vy = VW'(ds2_r) + VW'(yc2_r);
    end else begin
      vx = VW'(dc2_r) + VW'(ys2_r);
      vy = VW'(yc2_r) - VW'(ds2_r);
    end
    neg_vx = -vx;
    neg_vy = -vy;
    ax = vx[VW-1] ? neg_vx[AW-1:0] : vx[AW-1:0];
    ay = vy[VW-1] ? neg_vy[AW-1:0] : vy[AW-1:0];
    flags3_nxt.y_major = (ay >= ax);
    flags3_nxt.neg_x   = vx[VW-1];
    flags3_nxt.neg_y   = vy[VW-1];
    flags3_nxt.zero    = (ax == '0) && (ay == '0);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      maj3_r   <= flags3_nxt.y_major ? ay : ax;
      min3_r   <= flags3_nxt.y_major ? ax : ay;
      flags3_r <= flags3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      work4_r  <= NW'(min3_r) * NW'(cfg.max_speed);
      den4_r   <= maj3_r;
      flags4_r <= flags3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_work  = work4_r;
  assign out_den   = den4_r;
  assign out_flags = flags4_r;
endmodule
`default_nettype wire

// ===== design/rfvc_div_stage.sv =====
// One restoring division step: yields one quotient bit per pipeline stage.
`default_nettype none
module rfvc_div_stage #(
  parameter int COORD_WIDTH = rfvc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [COORD_WIDTH+rfvc_pkg::QUOT_W:0] in_work,
  input  wire logic [COORD_WIDTH:0]                  in_den,
  input  wire rfvc_pkg::rfvc_flags_t                 in_flags,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [COORD_WIDTH+rfvc_pkg::QUOT_W:0]      out_work,
  output logic [COORD_WIDTH:0]                       out_den,
  output rfvc_pkg::rfvc_flags_t                      out_flags
);
  import rfvc_pkg::*;

  localparam int AW = COORD_WIDTH + 1;
  localparam int NW = AW + QUOT_W;

  logic          en;
  logic          v_r;
  logic [AW:0]   trial;
  logic [AW:0]   diff;
  logic [NW-1:0] work_nxt;
  logic [NW-1:0] work_r;
  logic [AW-1:0] den_r;
  rfvc_flags_t   flags_r;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  // Upper part of the word is the partial remainder, the lower part shifts
  // dividend bits out and quotient bits in.
  always_comb begin
    trial = in_work[NW-1:QUOT_W-1];
    diff  = trial - {1'b0, in_den};
    if (trial >= {1'b0, in_den}) begin
      work_nxt = {diff[AW-1:0], in_work[QUOT_W-2:0], 1'b1};
    end else begin
      work_nxt = {trial[AW-1:0], in_work[QUOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r  <= work_nxt;
      den_r   <= in_den;
      flags_r <= in_flags;
    end
  end

  assign out_valid = v_r;
  assign out_work  = work_r;
  assign out_den   = den_r;
  assign out_flags = flags_r;
endmodule
`default_nettype wire

// ===== design/rfvc_checker.sv =====
// Port-level checker for the velocity command block, bound to the top level.
`default_nettype none
`include "robot_frame_velocity_command_defines.svh"
module rfvc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] speed_x,
  input wire logic [15:0] speed_y,
  input wire logic [14:0] turn_speed
);
  // A stalled result holds its value.
  `RFVC_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(speed_x) && $stable(speed_y) && $stable(turn_speed))
  // Speeds are bounded by a 15-bit magnitude, so the most negative code never shows.
  `RFVC_CHECK(a_speed_range, out_valid |-> speed_x != 16'h8000 && speed_y != 16'h8000)
  // Reset empties the pipeline and opens the input.
  `RFVC_CHECK_RST(a_reset_empty, !rst_n |=> !out_valid && in_ready)
endmodule

bind robot_frame_velocity_command rfvc_checker u_rfvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .speed_x    (out_chan.speed_x),
  .speed_y    (out_chan.speed_y),
  .turn_speed (out_chan.turn_speed)
);
`default_nettype wire

// ===== sim/robot_frame_velocity_command_test.sv =====
// Self-checking testbench for the robot-frame velocity command block.
`default_nettype none
module robot_frame_velocity_command_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rfvc_pkg::*;

  // The clock has a 4 ns period, and reset is held low at the start of the run.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  rfvc_in_if  in_chan ();
  rfvc_out_if out_chan ();
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = REG_FLIP_Y;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  robot_frame_velocity_command DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic [11:0]        heading;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [14:0]        turn;
  } command_t;

  // This is the testbench's own copy of the configuration registers.
  logic        mirror_y;
  logic        clockwise;
  logic [14:0] top_speed;
  logic        turn_enable;
  logic [14:0] tolerance;
  logic [14:0] turn_rate;

  // These are the Q0.15 sine values for the first quadrant, steps 0 through 1024.
  longint quadrant_sine [0:1024];

  command_t pending_commands[$];
  int mismatch_count = 0;
  int checked_count = 0;
  int sent_count = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // The first-quadrant sine is a Taylor series evaluated in Q30 fixed point.
  initial begin
    longint unsigned arg, term, sum, q15;
    for (int r = 0; r <= 1024; r++) begin
      arg = (64'd1686629713 * longint'(r)) >> 10;
      term = arg;
      sum = arg;
      for (int n = 1; n <= 8; n++) begin
        term = (term * arg) >> 30;
        term = (term * arg) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      q15 = (sum + 64'd16384) >> 15;
      if (q15 > 32767) begin
        q15 = 32767;
      end
      quadrant_sine[r] = longint'(q15);
    end
  end

  function automatic longint heading_sine(input logic [11:0] k);
    logic [9:0] r;
    r = k[9:0];
    case (k[11:10])
      2'd0: return quadrant_sine[r];
      2'd1: return quadrant_sine[1024 - r];
      2'd2: return -quadrant_sine[r];
      default: return -quadrant_sine[1024 - r];
    endcase
  endfunction

  // An arithmetic shift by 15 rounds toward minus infinity.
  function automatic longint shift_floor(input longint v);
    return v >>> 15;
  endfunction

  function automatic command_t velocity_command(input pose_t p);
    longint dx, dy, s, c, vx, vy, ax, ay, m, mag;
    command_t r;
    dx = longint'(p.target_x) - longint'(p.robot_x);
    dy = longint'(p.target_y) - longint'(p.robot_y);
    m = longint'(top_speed);
    r = '0;
    if (mirror_y) begin
      dy = -dy;
    end
    s = heading_sine(p.heading);
    c = heading_sine(p.heading + 12'd1024);
    if (clockwise) begin
      vx = shift_floor(dx * c) - shift_floor(dy * s);
      vy = shift_floor(dx * s) + shift_floor(dy * c);
    end else begin
      vx = shift_floor(dx * c) + shift_floor(dy * s);
      vy = shift_floor(dy * c) - shift_floor(dx * s);
    end
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    if (ax != 0 || ay != 0) begin
      // On a tie, the y component is the major component.
      if (ay >= ax) begin
        mag = (ax * m) / ay;
        r.vy = (vy > 0) ? m : -m;
        r.vx = (vx < 0) ? -mag : mag;
      end else begin
        mag = (ay * m) / ax;
        r.vx = (vx > 0) ? m : -m;
        r.vy = (vy < 0) ? -mag : mag;
      end
      if (turn_enable && !(mag < longint'(tolerance))) begin
        r.turn = turn_rate;
      end
    end
    return r;
  endfunction

  // The local copy is updated at the clock edge on which the register write is taken.
  task automatic write_register(input cfg_index_t idx, input logic [14:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_FLIP_Y:         mirror_y = value[0];
      REG_ROTATE_CW:      clockwise = value[0];
      REG_MAX_SPEED:      top_speed = value;
      REG_ANGLE_ADJUST:   turn_enable = value[0];
      REG_AXIS_TOLERANCE: tolerance = value;
      REG_MAX_TURN_SPEED: turn_rate = value;
      default: ;
    endcase
  endtask

  // The writes go out on back-to-back edges, and the enable drops after the last one.
  task automatic load_settings(input logic iy, input logic cw, input logic [14:0] ms,
                               input logic adj, input logic [14:0] tol, input logic [14:0] mt);
    write_register(REG_FLIP_Y, {14'd0, iy});
    write_register(REG_ROTATE_CW, {14'd0, cw});
    write_register(REG_MAX_SPEED, ms);
    write_register(REG_ANGLE_ADJUST, {14'd0, adj});
    write_register(REG_AXIS_TOLERANCE, tol);
    write_register(REG_MAX_TURN_SPEED, mt);
    cfg_we <= 1'b0;
  endtask

  // Register writes must come only while the block is idle, which the block itself
  // does not enforce. The wait lets every result arrive before the next phase.
  task automatic drain_pipeline();
    while (pending_commands.size() != 0) begin
      @(posedge clk);
    end
    repeat (25) @(posedge clk);
  endtask

  // The sender works in bursts of random length with random gaps between them.
  // The valid signal is driven only at the rising clock edge, and it stays high from
  // one transaction to the next within a burst.
  int burst_left = 0;

  task automatic send_pose(input pose_t p, input bit typed, input command_t want);
    int gap;
    command_t expected;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.robot_x <= p.robot_x;
    in_chan.robot_y <= p.robot_y;
    in_chan.robot_heading <= p.heading;
    in_chan.target_x <= p.target_x;
    in_chan.target_y <= p.target_y;
    expected = velocity_command(p);
    if (typed && expected != want) begin
      report("table row", longint'(expected), longint'(want));
    end
    pending_commands.push_back(expected);
    do @(posedge clk); while (!in_chan.ready);
    sent_count++;
  endtask

  task automatic end_burst();
    in_chan.valid <= 1'b0;
    burst_left = 0;
  endtask

  // The receiver stalls on a pattern of its own. It has periods of no stalls, periods
  // of light stalls, and periods of heavy stalls.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      case ((stall_phase / 97) % 3)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        default: out_chan.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Each accepted result is compared with the oldest expected result.
  always @(posedge clk) begin
    command_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_commands.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        want = pending_commands.pop_front();
        checked_count++;
        if (out_chan.speed_x !== want.vx) begin
          report("speed_x", out_chan.speed_x, want.vx);
        end
        if (out_chan.speed_y !== want.vy) begin
          report("speed_y", out_chan.speed_y, want.vy);
        end
        if (out_chan.turn_speed !== want.turn) begin
          report("turn_speed", out_chan.turn_speed, want.turn);
        end
      end
    end
  end

  typedef struct {
    pose_t    p;
    bit       typed;
    command_t want;
  } stimulus_row_t;

  function automatic pose_t random_pose(input int span);
    pose_t p;
    p.heading = $urandom_range(0, 4095);
    if (span == 0) begin
      p.robot_x = $urandom;
      p.robot_y = $urandom;
      p.target_x = $urandom;
      p.target_y = $urandom;
    end else begin
      p.robot_x = $urandom_range(0, 2 * span) - span;
      p.robot_y = $urandom_range(0, 2 * span) - span;
      p.target_x = p.robot_x + 16'($urandom_range(0, 2 * span) - span);
      p.target_y = p.robot_y + 16'($urandom_range(0, 2 * span) - span);
    end
    return p;
  endfunction

  initial begin
    stimulus_row_t rows[$];
    int phase_count;
    in_chan.valid = 1'b0;
    in_chan.robot_x = '0;
    in_chan.robot_y = '0;
    in_chan.robot_heading = '0;
    in_chan.target_x = '0;
    in_chan.target_y = '0;
    mirror_y = 1'b0;
    clockwise = 1'b0;
    top_speed = 15'd1000;
    turn_enable = 1'b0;
    tolerance = 15'd0;
    turn_rate = 15'd1000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first rows run with the reset settings. The expected values
    // are typed in only where they are obvious: a zero vector, and a pure axis vector
    // at heading zero, where the dominant component is exactly the maximum speed.
    rows.push_back('{'{16'sd0, 16'sd0, 12'd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 15'd0}});
    rows.push_back('{'{16'sd0, 16'sd0, 12'd0, 16'sd100, 16'sd0}, 1'b1,
                    '{16'sd1000, 16'sd0, 15'd0}});
    rows.push_back('{'{16'sd0, 16'sd0, 12'd0, 16'sd0, -16'sd100}, 1'b1,
                    '{16'sd0, -16'sd1000, 15'd0}});
    rows.push_back('{'{16'sd0, 16'sd0, 12'd0, 16'sd50, 16'sd50}, 1'b0, '0});
    rows.push_back('{'{-16'sd32768, -16'sd32768, 12'd0, 16'sd32767, 16'sd32767}, 1'b0, '0});
    rows.push_back('{'{16'sd32767, 16'sd32767, 12'd4095, -16'sd32768, -16'sd32768}, 1'b0, '0});
    rows.push_back('{'{16'sd32767, -16'sd32768, 12'd1024, -16'sd32768, 16'sd32767}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 12'd2048, 16'sd1, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 12'd3072, 16'sd0, 16'sd1}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 12'd512, 16'sd1000, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 12'd1, -16'sd3, 16'sd7}, 1'b0, '0});
    rows.push_back('{'{16'sd10, 16'sd10, 12'd1023, 16'sd10, 16'sd10}, 1'b1,
                    '{16'sd0, 16'sd0, 15'd0}});
    foreach (rows[i]) begin
      send_pose(rows[i].p, rows[i].typed, rows[i].want);
    end
    end_burst();
    drain_pipeline();

    // The next rows use the extreme settings: mirrored y, clockwise rotation, full
    // speeds, and a zero tolerance. With a zero tolerance, any nonzero vector turns.
    load_settings(1'b1, 1'b1, 15'h7FFF, 1'b1, 15'd0, 15'h7FFF);
    send_pose('{16'sd0, 16'sd0, 12'd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 15'd0});
    send_pose('{16'sd0, 16'sd0, 12'd0, 16'sd5, 16'sd0}, 1'b1,
              '{16'sd32767, 16'sd0, 15'h7FFF});
    send_pose('{-16'sd32768, 16'sd32767, 12'd2048, 16'sd32767, -16'sd32768}, 1'b0, '0);
    send_pose('{16'sd0, 16'sd0, 12'd300, 16'sd20, 16'sd20}, 1'b0, '0);
    end_burst();
    drain_pipeline();

    // With a zero maximum speed, every output is zero. The maximum tolerance keeps the
    // turn output off.
    load_settings(1'b0, 1'b0, 15'd0, 1'b1, 15'h7FFF, 15'd1);
    send_pose('{16'sd0, 16'sd0, 12'd0, 16'sd7, 16'sd3}, 1'b1, '{16'sd0, 16'sd0, 15'd0});
    send_pose('{16'sd1, 16'sd2, 12'd777, -16'sd9, 16'sd4}, 1'b0, '0);
    end_burst();
    drain_pipeline();

    // The random part cycles through several settings. Most poses use short
    // displacements, which bring out rounding and near-axis cases. The rest use the
    // full coordinate range.
    for (phase_count = 0; phase_count < 6; phase_count++) begin
      load_settings($urandom_range(0, 1), $urandom_range(0, 1),
                    (phase_count == 0) ? 15'h7FFF : 15'($urandom_range(1, 32767)),
                    $urandom_range(0, 1),
                    (phase_count % 2 == 0) ? 15'($urandom_range(0, 40))
                                           : 15'($urandom_range(0, 32767)),
                    $urandom_range(0, 32767));
      repeat (100) begin
        case ($urandom_range(0, 3))
          0: send_pose(random_pose(0), 1'b0, '0);
          1: send_pose(random_pose(3), 1'b0, '0);
          default: send_pose(random_pose(2000), 1'b0, '0);
        endcase
      end
      end_burst();
      drain_pipeline();
    end

    if (pending_commands.size() != 0) begin
      report("results still pending", pending_commands.size(), 0);
    end
    $display("Sent %0d poses over nine register settings. Checked %0d velocity commands.",
             sent_count, checked_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // This is a generous fixed limit on the run time.
  initial begin
    #2ms;
    $display("Timeout with %0d results still pending.", pending_commands.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
